>>> rtl/next_fit_heap_allocator_assert.svh
// assertion macros used by the allocator sequencer
// needs a clk and rst signal in the scope of each use
`ifndef NEXT_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define NEXT_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define NFHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define NFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/nfha_pkg.sv
// shared types, codes and defaults of the next-fit heap allocator
// no dependencies
`timescale 1ns / 1ps

package nfha_pkg;

  // default geometry
  localparam int DEF_ARENA_BYTES   = 65536;
  localparam int DEF_HEADER_BYTES  = 16;
  localparam int DEF_GRANULE_BYTES = 8;

  // fixed field widths
  localparam int OP_W    = 3;
  localparam int ADDR_W  = 16;
  localparam int SIZE_W  = 17;
  localparam int STAT_W  = 2;
  localparam int ALIGN_W = 7;
  localparam int MAX_ADDR = 65535;

  // operation codes
  localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd2;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_OOM    = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_DOUBLE = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_REJECT = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] length;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] payload_address;
    logic [SIZE_W-1:0] block_bytes;
    logic [STAT_W-1:0] status;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SRCH,
    ST_ALLOC,
    ST_ALLOC_CUR,
    ST_FIND,
    ST_MRG_RDN,
    ST_MRG_N,
    ST_MRG_P,
    ST_ADD_WALK,
    ST_ADD_INS,
    ST_ADD_LINK,
    ST_DONE
  } ctrl_state_t;

endpackage

>>> rtl/nfha_if.sv
// request and response channel interfaces of the allocator
// depends on nfha_pkg for field widths
`timescale 1ns / 1ps

interface nfha_req_if;
  logic                          valid;
  logic                          ready;
  logic [nfha_pkg::OP_W-1:0]     op;
  logic [nfha_pkg::ADDR_W-1:0]   address;
  logic [nfha_pkg::SIZE_W-1:0]   length;
  modport source (output valid, op, address, length, input ready);
  modport sink (input valid, op, address, length, output ready);
endinterface

interface nfha_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [nfha_pkg::ADDR_W-1:0]   payload_address;
  logic [nfha_pkg::SIZE_W-1:0]   block_bytes;
  logic [nfha_pkg::STAT_W-1:0]   status;
  modport source (output valid, payload_address, block_bytes, status, input ready);
  modport sink (input valid, payload_address, block_bytes, status, output ready);
endinterface

>>> rtl/nfha_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps

module nfha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/nfha_ctrl.sv
// sequencer of the allocator: list walks, split, merge over the header ram
// depends on nfha_pkg and next_fit_heap_allocator_assert.svh
`timescale 1ns / 1ps
`include "next_fit_heap_allocator_assert.svh"

module nfha_ctrl #(
  parameter int ARENA_BYTES   = nfha_pkg::DEF_ARENA_BYTES,
  parameter int HEADER_BYTES  = nfha_pkg::DEF_HEADER_BYTES,
  parameter int GRANULE_BYTES = nfha_pkg::DEF_GRANULE_BYTES,
  localparam int SLOTS = ARENA_BYTES / GRANULE_BYTES,
  localparam int SW    = $clog2(SLOTS + 1),
  localparam int MAW   = $clog2(SLOTS),
  localparam int DW    = nfha_pkg::SIZE_W + 1 + SW
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  nfha_pkg::item_t               item,
  input  logic [nfha_pkg::ALIGN_W-1:0]  align,
  input  logic                          res_free,
  output logic                          ready,
  output logic                          done,
  output nfha_pkg::result_t             result,
  output logic                          mem_we,
  output logic [MAW-1:0]                mem_waddr_o,
  output logic [DW-1:0]                 mem_wdata,
  output logic [MAW-1:0]                mem_raddr_o,
  input  logic [DW-1:0]                 mem_rdata
);

  localparam int GSH = $clog2(GRANULE_BYTES);
  localparam int WW  = (($clog2(ARENA_BYTES) > nfha_pkg::SIZE_W) ?
                        $clog2(ARENA_BYTES) : nfha_pkg::SIZE_W) + 2;
  localparam int NW  = nfha_pkg::SIZE_W + 1;
  localparam logic [SW-1:0] NIL = SW'(SLOTS);

  nfha_pkg::ctrl_state_t state, state_next;

  logic [SW-1:0] head, head_next, cursor, cursor_next;
  logic [nfha_pkg::OP_W-1:0] op_r, op_next;
  logic [nfha_pkg::ADDR_W-1:0] addr_r, addr_next;
  logic [nfha_pkg::SIZE_W-1:0] len_r, len_next;
  logic [SW-1:0] cur, cur_next, prv, prv_next, steps, steps_next;
  logic [SW-1:0] start_r, start_next, tgt, tgt_next, hlink, hlink_next, nxo, nxo_next;
  logic [NW-1:0] need, need_next;
  logic second, second_next, pfree, pfree_next;
  logic [nfha_pkg::SIZE_W-1:0] hsize, hsize_next, psize, psize_next;
  nfha_pkg::result_t res, res_next;
  logic [SW-1:0] mem_waddr, mem_raddr;

  // read data fields
  logic [nfha_pkg::SIZE_W-1:0] r_size;
  logic r_free;
  logic [SW-1:0] r_link;
  assign r_size = mem_rdata[DW-1 -: nfha_pkg::SIZE_W];
  assign r_free = mem_rdata[SW];
  assign r_link = mem_rdata[SW-1:0];

  // request checks
  logic [WW-1:0] addr_w, len_w, cur_byte, prv_byte, nxo_byte;
  logic [nfha_pkg::ADDR_W-1:0] hdr;
  logic region_ok, add_ok, ptr_ok;
  logic [SW-1:0] s_add, tgt_ptr, start_c, steps_inc;
  logic [nfha_pkg::ALIGN_W-1:0] a_eff;
  logic [NW-1:0] need_c;

  assign addr_w   = WW'(addr_r);
  assign len_w    = WW'(len_r);
  assign cur_byte = WW'(cur) << GSH;
  assign prv_byte = WW'(prv) << GSH;
  assign nxo_byte = WW'(nxo) << GSH;
  assign hdr      = addr_r - nfha_pkg::ADDR_W'(HEADER_BYTES);
  assign region_ok = (addr_r[GSH-1:0] == '0) && (len_w >= WW'(HEADER_BYTES))
                   && (addr_w + len_w <= WW'(ARENA_BYTES))
                   && (addr_w + WW'(HEADER_BYTES) <= WW'(nfha_pkg::MAX_ADDR));
  assign add_ok  = region_ok && (addr_r != '0) && (len_w > WW'(HEADER_BYTES));
  assign ptr_ok  = (addr_r != '0) && (addr_w >= WW'(HEADER_BYTES))
                 && (hdr[GSH-1:0] == '0) && (WW'(hdr) < WW'(ARENA_BYTES));
  assign s_add   = SW'(addr_r >> GSH);
  assign tgt_ptr = SW'(hdr >> GSH);
  assign start_c = (cursor < NIL) ? cursor : head;
  assign steps_inc = steps + SW'(1);
  assign a_eff   = (align != '0) ? align : nfha_pkg::ALIGN_W'(GRANULE_BYTES);
  assign need_c  = (NW'(len_r) + NW'(a_eff) - NW'(1)) & ~(NW'(a_eff) - NW'(1));

  // walk decisions
  logic srch_hit, srch_cont, srch_retry, find_cont, walk_cont, dup;
  assign srch_hit   = r_free && (NW'(r_size) >= need);
  assign srch_cont  = (r_link < NIL) && (steps_inc < NIL);
  assign srch_retry = !second && (start_r != head) && (head < NIL);
  assign find_cont  = (r_link < NIL) && (steps_inc < NIL);
  assign walk_cont  = (r_link < NIL) && (r_link < tgt) && (steps < NIL);
  assign dup        = (cur == tgt) || (r_link == tgt);

  // split check
  logic [WW-1:0] total, naddr;
  logic split_ok;
  logic [SW-1:0] n_slot;
  assign total    = WW'(need) + WW'(HEADER_BYTES);
  assign naddr    = cur_byte + total;
  assign split_ok = (WW'(hsize) >= total + WW'(HEADER_BYTES) + WW'(align))
                  && (naddr[GSH-1:0] == '0) && (naddr < WW'(ARENA_BYTES))
                  && (naddr + WW'(HEADER_BYTES) <= WW'(nfha_pkg::MAX_ADDR));
  assign n_slot   = SW'(naddr >> GSH);

  // merge checks
  logic mn, mp;
  logic [nfha_pkg::SIZE_W-1:0] hs_m, ps_m;
  assign mn   = (nxo < NIL) && r_free
              && (cur_byte + WW'(HEADER_BYTES) + WW'(hsize) == nxo_byte);
  assign hs_m = nfha_pkg::SIZE_W'(WW'(hsize) + WW'(HEADER_BYTES) + WW'(r_size));
  assign mp   = (prv < NIL) && r_free
              && (prv_byte + WW'(HEADER_BYTES) + WW'(r_size) == cur_byte);
  assign ps_m = nfha_pkg::SIZE_W'(WW'(r_size) + WW'(HEADER_BYTES) + WW'(hsize));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      nfha_pkg::ST_IDLE: if (start) state_next = nfha_pkg::ST_DISPATCH;
      nfha_pkg::ST_DISPATCH: begin
        case (op_r)
          nfha_pkg::OP_ALLOC:
            state_next = (start_c < NIL) ? nfha_pkg::ST_SRCH : nfha_pkg::ST_DONE;
          nfha_pkg::OP_FREE, nfha_pkg::OP_QUERY:
            state_next = (ptr_ok && head < NIL) ? nfha_pkg::ST_FIND : nfha_pkg::ST_DONE;
          nfha_pkg::OP_ADD: begin
            if (!add_ok) state_next = nfha_pkg::ST_DONE;
            else if (head < NIL && s_add >= head) state_next = nfha_pkg::ST_ADD_WALK;
            else state_next = nfha_pkg::ST_ADD_INS;
          end
          default: state_next = nfha_pkg::ST_DONE;
        endcase
      end
      nfha_pkg::ST_SRCH: begin
        if (srch_hit) state_next = nfha_pkg::ST_ALLOC;
        else if (!srch_cont && !srch_retry) state_next = nfha_pkg::ST_DONE;
      end
      nfha_pkg::ST_ALLOC:     state_next = nfha_pkg::ST_ALLOC_CUR;
      nfha_pkg::ST_ALLOC_CUR: state_next = nfha_pkg::ST_DONE;
      nfha_pkg::ST_FIND: begin
        if (cur == tgt) begin
          state_next = (op_r == nfha_pkg::OP_QUERY || r_free) ?
                       nfha_pkg::ST_DONE : nfha_pkg::ST_MRG_RDN;
        end else if (!find_cont) begin
          state_next = nfha_pkg::ST_DONE;
        end
      end
      nfha_pkg::ST_MRG_RDN: state_next = nfha_pkg::ST_MRG_N;
      nfha_pkg::ST_MRG_N:   state_next = nfha_pkg::ST_MRG_P;
      nfha_pkg::ST_MRG_P:   state_next = nfha_pkg::ST_DONE;
      nfha_pkg::ST_ADD_WALK: begin
        if (!walk_cont) state_next = dup ? nfha_pkg::ST_DONE : nfha_pkg::ST_ADD_INS;
      end
      nfha_pkg::ST_ADD_INS:
        state_next = (cur >= NIL) ? nfha_pkg::ST_MRG_RDN : nfha_pkg::ST_ADD_LINK;
      nfha_pkg::ST_ADD_LINK: state_next = nfha_pkg::ST_MRG_RDN;
      nfha_pkg::ST_DONE: if (res_free) state_next = nfha_pkg::ST_IDLE;
      default: state_next = nfha_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory port control
  always_comb begin
    head_next = head;   cursor_next = cursor; op_next = op_r;  addr_next = addr_r;
    len_next = len_r;   cur_next = cur;       prv_next = prv;  steps_next = steps;
    start_next = start_r; tgt_next = tgt;     hlink_next = hlink; nxo_next = nxo;
    need_next = need;   second_next = second; pfree_next = pfree;
    hsize_next = hsize; psize_next = psize;   res_next = res;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;
    case (state)
      nfha_pkg::ST_IDLE: begin
        if (start) begin
          op_next = item.op; addr_next = item.address; len_next = item.length;
          res_next = '0;
        end
      end
      nfha_pkg::ST_DISPATCH: begin
        need_next   = need_c;
        start_next  = start_c;
        tgt_next    = (op_r == nfha_pkg::OP_ADD) ? s_add : tgt_ptr;
        steps_next  = '0;
        second_next = 1'b0;
        prv_next    = NIL;
        case (op_r)
          nfha_pkg::OP_INIT: begin
            if (region_ok) begin
              mem_we = 1'b1; mem_waddr = s_add;
              mem_wdata = {nfha_pkg::SIZE_W'(len_r - nfha_pkg::SIZE_W'(HEADER_BYTES)),
                           1'b1, NIL};
              head_next = s_add; cursor_next = s_add;
            end else begin
              res_next.status = nfha_pkg::STATUS_REJECT;
            end
          end
          nfha_pkg::OP_ALLOC: begin
            if (start_c < NIL) begin
              mem_raddr = start_c; cur_next = start_c;
            end else begin
              res_next.status = nfha_pkg::STATUS_OOM;
            end
          end
          nfha_pkg::OP_FREE, nfha_pkg::OP_QUERY: begin
            if (ptr_ok && head < NIL) begin
              mem_raddr = head; cur_next = head;
            end else begin
              res_next.status = nfha_pkg::STATUS_REJECT;
            end
          end
          nfha_pkg::OP_ADD: begin
            if (!add_ok) begin
              res_next.status = nfha_pkg::STATUS_REJECT;
            end else if (head < NIL && s_add >= head) begin
              mem_raddr = head; cur_next = head;
            end else begin
              cur_next = NIL;
            end
          end
          default: res_next.status = nfha_pkg::STATUS_REJECT;
        endcase
      end
      // next-fit search, one block a cycle
      nfha_pkg::ST_SRCH: begin
        if (srch_hit) begin
          hsize_next = r_size; hlink_next = r_link;
        end else if (srch_cont) begin
          mem_raddr = r_link; cur_next = r_link; steps_next = steps_inc;
        end else if (srch_retry) begin
          second_next = 1'b1; mem_raddr = head; cur_next = head; steps_next = '0;
        end else begin
          res_next.status = nfha_pkg::STATUS_OOM;
        end
      end
      // split off the tail as a new free block when the block found is large enough
      nfha_pkg::ST_ALLOC: begin
        if (split_ok) begin
          mem_we = 1'b1; mem_waddr = n_slot;
          mem_wdata = {nfha_pkg::SIZE_W'(WW'(hsize) - total), 1'b1, hlink};
          hsize_next = need[nfha_pkg::SIZE_W-1:0];
          hlink_next = n_slot;
        end
      end
      nfha_pkg::ST_ALLOC_CUR: begin
        mem_we = 1'b1; mem_waddr = cur; mem_wdata = {hsize, 1'b0, hlink};
        cursor_next = (hlink < NIL) ? hlink : head;
        res_next.payload_address = nfha_pkg::ADDR_W'(cur_byte + WW'(HEADER_BYTES));
        res_next.block_bytes = hsize;
      end
      // predecessor walk for free and query
      nfha_pkg::ST_FIND: begin
        if (cur == tgt) begin
          hsize_next = r_size; hlink_next = r_link;
          res_next.block_bytes = r_size;
          if (op_r != nfha_pkg::OP_QUERY && r_free) begin
            res_next.status = nfha_pkg::STATUS_DOUBLE;
          end
        end else if (find_cont) begin
          prv_next = cur; cur_next = r_link; mem_raddr = r_link; steps_next = steps_inc;
        end else begin
          res_next.status = nfha_pkg::STATUS_REJECT;
        end
      end
      // merge with the forward neighbour
      nfha_pkg::ST_MRG_RDN: begin
        nxo_next = hlink; mem_raddr = hlink;
      end
      nfha_pkg::ST_MRG_N: begin
        mem_we = 1'b1; mem_waddr = cur;
        if (mn) begin
          hsize_next = hs_m; hlink_next = r_link;
          mem_wdata = {hs_m, 1'b1, r_link};
        end else begin
          mem_wdata = {hsize, 1'b1, hlink};
        end
        mem_raddr = prv;
      end
      // merge into the backward neighbour and repair the cursor
      nfha_pkg::ST_MRG_P: begin
        if (mp) begin
          mem_we = 1'b1; mem_waddr = prv; mem_wdata = {ps_m, 1'b1, hlink};
        end
        if (cursor >= NIL || cursor == nxo || (mp && cursor == cur)) begin
          cursor_next = mp ? prv : cur;
        end
      end
      // ordered insertion point for a new region
      nfha_pkg::ST_ADD_WALK: begin
        if (walk_cont) begin
          cur_next = r_link; steps_next = steps_inc; mem_raddr = r_link;
        end else begin
          hlink_next = r_link; psize_next = r_size; pfree_next = r_free;
          if (dup) res_next.status = nfha_pkg::STATUS_REJECT;
        end
      end
      nfha_pkg::ST_ADD_INS: begin
        mem_we = 1'b1; mem_waddr = tgt;
        hsize_next = nfha_pkg::SIZE_W'(len_r - nfha_pkg::SIZE_W'(HEADER_BYTES));
        if (cur >= NIL) begin
          mem_wdata = {hsize_next, 1'b1, head};
          hlink_next = head; head_next = tgt; prv_next = NIL; cur_next = tgt;
        end else begin
          mem_wdata = {hsize_next, 1'b1, hlink};
          prv_next = cur;
        end
      end
      nfha_pkg::ST_ADD_LINK: begin
        mem_we = 1'b1; mem_waddr = prv; mem_wdata = {psize, pfree, tgt};
        cur_next = tgt;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nfha_pkg::ST_IDLE;
      head <= NIL;
      cursor <= NIL;
    end else begin
      state <= state_next;
      head <= head_next;
      cursor <= cursor_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r <= op_next;     addr_r <= addr_next;   len_r <= len_next;
    cur <= cur_next;     prv <= prv_next;       steps <= steps_next;
    start_r <= start_next; tgt <= tgt_next;     hlink <= hlink_next;
    nxo <= nxo_next;     need <= need_next;     second <= second_next;
    pfree <= pfree_next; hsize <= hsize_next;   psize <= psize_next;
    res <= res_next;
  end

  assign ready  = (state == nfha_pkg::ST_IDLE);
  assign done   = (state == nfha_pkg::ST_DONE) && res_free;
  assign result = res;
  assign mem_waddr_o = mem_waddr[MAW-1:0];
  assign mem_raddr_o = mem_raddr[MAW-1:0];

  // checks
  `NFHA_ASSERT_NOW(a_no_write_idle, state == nfha_pkg::ST_IDLE, !mem_we, "ram write while idle")
  `NFHA_ASSERT_NEXT(a_done_single, done, !done, "result transfer repeated")
  `NFHA_ASSERT_NEXT(a_start_dispatch, start, state == nfha_pkg::ST_DISPATCH, "item not dispatched")

endmodule

>>> rtl/next_fit_heap_allocator.sv
// Next-fit heap allocator: one result per request, one request in flight at a time. Init,
// unknown codes and requests rejected before any list access need no list walk; alloc visits
// block headers in a next-fit search from the cursor (up to two passes over the list) and,
// when one fits, splits and marks it; free and query walk the list to the target block, and a
// free then merges it with its free neighbours; add-region goes in at the list head or after a
// walk to the insertion point, then merges. A stalled result holds the sequencer until the
// output register frees. The rate is set by the single read port of the header ram, which the
// list walks use one header per cycle.
// depends on nfha_pkg, nfha_if, nfha_ram and nfha_ctrl
`timescale 1ns / 1ps

module next_fit_heap_allocator #(
  parameter int ARENA_BYTES   = nfha_pkg::DEF_ARENA_BYTES,
  parameter int HEADER_BYTES  = nfha_pkg::DEF_HEADER_BYTES,
  parameter int GRANULE_BYTES = nfha_pkg::DEF_GRANULE_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [nfha_pkg::ALIGN_W-1:0] cfg_wr_data,
  nfha_req_if.sink                     req,
  nfha_rsp_if.source                   rsp
);

  localparam int SLOTS = ARENA_BYTES / GRANULE_BYTES;
  localparam int SW    = $clog2(SLOTS + 1);
  localparam int MAW   = $clog2(SLOTS);
  localparam int DW    = nfha_pkg::SIZE_W + 1 + SW;

  logic [nfha_pkg::ALIGN_W-1:0] align;
  logic ctrl_ready, ctrl_done, start, res_free, out_valid;
  nfha_pkg::item_t item;
  nfha_pkg::result_t result, out_res;
  logic mem_we;
  logic [MAW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;

  // alignment register
  always_ff @(posedge clk) begin
    if (rst) begin
      align <= '0;
    end else if (cfg_wr_en) begin
      align <= cfg_wr_data;
    end
  end

  // request side
  assign req.ready = ctrl_ready;
  assign start = req.valid && ctrl_ready;
  assign item = '{op: req.op, address: req.address, length: req.length};

  // output register
  assign res_free = !out_valid || rsp.ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl_done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (ctrl_done) out_res <= result;
  end
  assign rsp.valid = out_valid;
  assign rsp.payload_address = out_res.payload_address;
  assign rsp.block_bytes = out_res.block_bytes;
  assign rsp.status = out_res.status;

  nfha_ctrl #(
    .ARENA_BYTES(ARENA_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .GRANULE_BYTES(GRANULE_BYTES)
  ) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .item(item), .align(align),
    .res_free(res_free), .ready(ctrl_ready), .done(ctrl_done), .result(result),
    .mem_we(mem_we), .mem_waddr_o(mem_waddr), .mem_wdata(mem_wdata),
    .mem_raddr_o(mem_raddr), .mem_rdata(mem_rdata)
  );

  // header store: size, free flag and link per granule slot
  nfha_ram #(
    .WIDTH(DW),
    .DEPTH(SLOTS)
  ) u_hdr_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

endmodule

>>> bench/tb_next_fit_heap_allocator.sv
// self-checking bench for the next-fit heap allocator: directed and random request streams
// depends on nfha_pkg, nfha_if and the next_fit_heap_allocator rtl
`timescale 1ns / 1ps

module tb_next_fit_heap_allocator;

  localparam int          HDR      = nfha_pkg::DEF_HEADER_BYTES;
  localparam int          GRAN     = nfha_pkg::DEF_GRANULE_BYTES;
  localparam int          ARENA    = nfha_pkg::DEF_ARENA_BYTES;
  localparam int unsigned NSLOT    = ARENA / GRAN;
  localparam int unsigned NIL_SLOT = NSLOT;
  localparam int unsigned SZ_MASK  = 32'h1FFFF;
  localparam logic [nfha_pkg::OP_W-1:0] OP_TOP = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [nfha_pkg::ALIGN_W-1:0] cfg_wr_data = '0;

  nfha_req_if req ();
  nfha_rsp_if rsp ();

  next_fit_heap_allocator DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .rsp         (rsp)
  );

  always #10 clk = ~clk;

  // heap image kept alongside the block
  int unsigned hdr_size [NSLOT];
  bit          hdr_free [NSLOT];
  int unsigned hdr_link [NSLOT];
  int unsigned first_slot = NIL_SLOT;
  int unsigned cursor_slot = NIL_SLOT;
  int unsigned align_reg = 0;

  nfha_pkg::result_t pending_results [$];
  logic [15:0]  live_blocks [$];
  logic [15:0]  freed_blocks [$];
  int           mismatches = 0;
  int           stall_pct = 0;
  int           gap_max = 0;
  int           burst_left = 0;

  function automatic int unsigned block_end(int unsigned s);
    return s * GRAN + HDR + hdr_size[s];
  endfunction

  // locate a header in the list and report its predecessor
  function automatic bit locate_header(int unsigned tgt, output int unsigned pv);
    int unsigned cur, p, steps;
    cur = first_slot; p = NIL_SLOT; steps = 0; pv = NIL_SLOT;
    while (cur < NIL_SLOT && steps < NSLOT) begin
      if (cur == tgt) begin
        pv = p;
        return 1'b1;
      end
      p = cur; cur = hdr_link[cur]; steps++;
    end
    return 1'b0;
  endfunction

  function automatic int unsigned next_fit_from(int unsigned start, int unsigned need);
    int unsigned cur, steps;
    cur = start; steps = 0;
    while (cur < NIL_SLOT && steps < NSLOT) begin
      if (hdr_free[cur] && hdr_size[cur] >= need) return cur;
      cur = hdr_link[cur]; steps++;
    end
    return NIL_SLOT;
  endfunction

  // coalesce with touching free neighbours, then repair the cursor
  function automatic void coalesce(int unsigned h, int unsigned pv);
    int unsigned nx, surv;
    nx = hdr_link[h]; surv = h;
    if (nx < NIL_SLOT && hdr_free[nx] && block_end(h) == nx * GRAN) begin
      hdr_size[h] = (hdr_size[h] + HDR + hdr_size[nx]) & SZ_MASK;
      hdr_link[h] = hdr_link[nx];
    end
    if (pv < NIL_SLOT && hdr_free[pv] && block_end(pv) == h * GRAN) begin
      hdr_size[pv] = (hdr_size[pv] + HDR + hdr_size[h]) & SZ_MASK;
      hdr_link[pv] = hdr_link[h];
      surv = pv;
    end
    if (cursor_slot >= NIL_SLOT || cursor_slot == nx || (surv != h && cursor_slot == h))
      cursor_slot = surv;
  endfunction

  function automatic bit region_fits(int unsigned ad, int unsigned ln);
    return (ad % GRAN == 0) && (ln >= HDR) && (ad + ln <= ARENA) && (ad + HDR <= 32'hFFFF);
  endfunction

  // heap operation as the block should perform it
  function automatic nfha_pkg::result_t heap_apply(logic [nfha_pkg::OP_W-1:0] op,
                                                   logic [15:0] a16, logic [16:0] l17);
    nfha_pkg::result_t r;
    int unsigned ad, ln, s, pv, al, need, start, cur, total, naddr, n, steps, hdr;
    bit ok;
    ad = 32'(a16); ln = 32'(l17); r = '0; pv = NIL_SLOT;
    case (op)
      nfha_pkg::OP_INIT: begin
        if (!region_fits(ad, ln)) r.status = nfha_pkg::STATUS_REJECT;
        else begin
          s = ad / GRAN;
          hdr_size[s] = (ln - HDR) & SZ_MASK; hdr_free[s] = 1'b1; hdr_link[s] = NIL_SLOT;
          first_slot = s; cursor_slot = s;
        end
      end
      nfha_pkg::OP_ALLOC: begin
        al = (align_reg != 0) ? align_reg : GRAN;
        need = (ln + al - 1) & ~(al - 1);
        start = (cursor_slot < NIL_SLOT) ? cursor_slot : first_slot;
        cur = next_fit_from(start, need);
        if (cur >= NIL_SLOT && start != first_slot) cur = next_fit_from(first_slot, need);
        if (cur >= NIL_SLOT) r.status = nfha_pkg::STATUS_OOM;
        else begin
          total = need + HDR;
          if (hdr_size[cur] >= total + HDR + align_reg) begin
            naddr = cur * GRAN + total;
            if (naddr % GRAN == 0 && naddr < ARENA && naddr + HDR <= 32'hFFFF) begin
              n = naddr / GRAN;
              hdr_size[n] = (hdr_size[cur] - total) & SZ_MASK;
              hdr_free[n] = 1'b1;
              hdr_link[n] = hdr_link[cur];
              hdr_size[cur] = need & SZ_MASK;
              hdr_link[cur] = n;
            end
          end
          hdr_free[cur] = 1'b0;
          cursor_slot = (hdr_link[cur] < NIL_SLOT) ? hdr_link[cur] : first_slot;
          r.payload_address = nfha_pkg::ADDR_W'((cur * GRAN + HDR) & 32'hFFFF);
          r.block_bytes = nfha_pkg::SIZE_W'(hdr_size[cur]);
        end
      end
      nfha_pkg::OP_FREE, nfha_pkg::OP_QUERY: begin
        ok = 1'b0;
        if (ad != 0 && ad >= HDR) begin
          hdr = ad - HDR;
          if (hdr % GRAN == 0 && hdr < ARENA) begin
            s = hdr / GRAN;
            ok = locate_header(s, pv);
          end
        end
        if (!ok) r.status = nfha_pkg::STATUS_REJECT;
        else if (op == nfha_pkg::OP_QUERY) r.block_bytes = nfha_pkg::SIZE_W'(hdr_size[s]);
        else if (hdr_free[s]) begin
          r.status = nfha_pkg::STATUS_DOUBLE;
          r.block_bytes = nfha_pkg::SIZE_W'(hdr_size[s]);
        end else begin
          hdr_free[s] = 1'b1; r.block_bytes = nfha_pkg::SIZE_W'(hdr_size[s]);
          coalesce(s, pv);
        end
      end
      nfha_pkg::OP_ADD: begin
        ok = region_fits(ad, ln) && ad != 0 && ln > HDR;
        cur = NIL_SLOT; steps = 0; s = ad / GRAN;
        if (ok && first_slot < NIL_SLOT && s >= first_slot) begin
          cur = first_slot;
          while (hdr_link[cur] < NIL_SLOT && hdr_link[cur] < s && steps < NSLOT) begin
            cur = hdr_link[cur]; steps++;
          end
          if (cur == s || hdr_link[cur] == s) ok = 1'b0;
        end
        if (!ok) r.status = nfha_pkg::STATUS_REJECT;
        else begin
          hdr_size[s] = (ln - HDR) & SZ_MASK; hdr_free[s] = 1'b1;
          if (cur >= NIL_SLOT) begin
            hdr_link[s] = first_slot; first_slot = s; pv = NIL_SLOT;
          end else begin
            hdr_link[s] = hdr_link[cur]; hdr_link[cur] = s; pv = cur;
          end
          coalesce(s, pv);
          if (cursor_slot >= NIL_SLOT) cursor_slot = first_slot;
        end
      end
      default: r.status = nfha_pkg::STATUS_REJECT;
    endcase
    return r;
  endfunction

  // one request transfer, then the next in the burst or a gap
  task automatic send_req(logic [nfha_pkg::OP_W-1:0] op, logic [15:0] ad, logic [16:0] ln);
    nfha_pkg::result_t r;
    req.valid <= 1'b1; req.op <= op; req.address <= ad; req.length <= ln;
    do @(posedge clk); while (!req.ready);
    r = heap_apply(op, ad, ln);
    pending_results.push_back(r);
    if (op == nfha_pkg::OP_INIT && r.status == nfha_pkg::STATUS_OK) live_blocks.delete();
    if (op == nfha_pkg::OP_ALLOC && r.status == nfha_pkg::STATUS_OK)
      live_blocks.push_back(r.payload_address);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      if (gap_max > 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  // hold off until the block has answered everything
  task automatic wait_all_results();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_alignment(int unsigned v);
    wait_all_results();
    cfg_wr_en <= 1'b1; cfg_wr_data <= v[nfha_pkg::ALIGN_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    align_reg = v;
  endtask

  // empty heap, unknown codes and bad init requests
  task automatic test_empty_heap();
    send_req(nfha_pkg::OP_ALLOC, 16'd0, 17'd8);
    send_req(nfha_pkg::OP_FREE, 16'h0100, 17'd0);
    send_req(nfha_pkg::OP_QUERY, 16'd0, 17'd0);
    for (int o = nfha_pkg::OP_QUERY + 1; o <= OP_TOP; o++)
      send_req(o[nfha_pkg::OP_W-1:0], 16'hFFFF, 17'h10000);
    send_req(nfha_pkg::OP_INIT, 16'd4, 17'd256);
    send_req(nfha_pkg::OP_INIT, 16'd0, 17'd15);
    send_req(nfha_pkg::OP_INIT, 16'hFF00, 17'd512);
    send_req(nfha_pkg::OP_INIT, 16'hFFF8, 17'd16);
  endtask

  // alloc, free, double free, query and bad pointers
  task automatic test_alloc_free();
    send_req(nfha_pkg::OP_INIT, 16'd0, 17'd4096);
    send_req(nfha_pkg::OP_ALLOC, 16'd0, 17'd0);
    send_req(nfha_pkg::OP_ALLOC, 16'd0, 17'd1);
    send_req(nfha_pkg::OP_ALLOC, 16'd0, 17'h10000);
    send_req(nfha_pkg::OP_ALLOC, 16'd0, 17'd100);
    send_req(nfha_pkg::OP_FREE, 16'd16, 17'd0);
    send_req(nfha_pkg::OP_FREE, 16'd16, 17'd0);
    send_req(nfha_pkg::OP_QUERY, 16'd40, 17'd0);
    send_req(nfha_pkg::OP_FREE, 16'd8, 17'd0);
    send_req(nfha_pkg::OP_FREE, 16'd19, 17'd0);
    send_req(nfha_pkg::OP_FREE, 16'h8000, 17'd0);
  endtask

  // region insertion, rejects, duplicates and a region touching the end of the first heap
  task automatic test_add_region();
    send_req(nfha_pkg::OP_ADD, 16'd0, 17'd256);
    send_req(nfha_pkg::OP_ADD, 16'd8192, 17'd16);
    send_req(nfha_pkg::OP_ADD, 16'd8192, 17'd256);
    send_req(nfha_pkg::OP_ADD, 16'd8192, 17'd256);
    send_req(nfha_pkg::OP_ADD, 16'd4096, 17'd512);
  endtask

  // mostly well-formed alloc/free traffic on small arenas, some noise
  task automatic test_random_traffic(int count);
    int k, idx;
    logic [15:0] p;
    send_req(nfha_pkg::OP_INIT, 16'($urandom_range(0, 64) * GRAN),
             17'($urandom_range(512, 8192)));
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (i == count / 2) wait_all_results();
      if (k < 40) begin
        if ($urandom_range(0, 9) == 0)
          send_req(nfha_pkg::OP_ALLOC, 16'd0, 17'($urandom_range(0, 65536)));
        else
          send_req(nfha_pkg::OP_ALLOC, 16'd0, 17'($urandom_range(0, 300)));
      end else if (k < 68) begin
        if (live_blocks.size() != 0) begin
          idx = $urandom_range(0, live_blocks.size() - 1);
          p = live_blocks[idx];
          live_blocks.delete(idx);
          freed_blocks.push_back(p);
          if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
          send_req(nfha_pkg::OP_FREE, p, 17'($urandom_range(0, 131071)));
        end else send_req(nfha_pkg::OP_FREE, 16'($urandom_range(0, 65535)), 17'd0);
      end else if (k < 74) begin
        if (freed_blocks.size() != 0)
          send_req(nfha_pkg::OP_FREE,
                   freed_blocks[$urandom_range(0, freed_blocks.size() - 1)], 17'd0);
        else send_req(nfha_pkg::OP_FREE, 16'($urandom_range(0, 65535)), 17'd0);
      end else if (k < 84) begin
        if (live_blocks.size() != 0 && k < 80)
          send_req(nfha_pkg::OP_QUERY,
                   live_blocks[$urandom_range(0, live_blocks.size() - 1)], 17'd0);
        else send_req(nfha_pkg::OP_QUERY, 16'($urandom_range(0, 65535)),
                      17'($urandom_range(0, 65536)));
      end else if (k < 91) begin
        send_req(nfha_pkg::OP_ADD, 16'($urandom_range(0, 8190) * GRAN),
                 17'($urandom_range(0, 2048)));
      end else if (k < 94) begin
        send_req(nfha_pkg::OP_INIT, 16'($urandom_range(0, 512) * GRAN),
                 17'($urandom_range(16, 8192)));
      end else if (k < 97) begin
        send_req(nfha_pkg::OP_INIT, 16'($urandom_range(0, 65535)),
                 17'($urandom_range(0, 65536)));
      end else begin
        send_req(3'($urandom_range(nfha_pkg::OP_QUERY + 1, OP_TOP)),
                 16'($urandom_range(0, 65535)), 17'($urandom_range(0, 65536)));
      end
    end
  endtask

  // response checking against the oldest expectation
  always @(posedge clk) begin
    nfha_pkg::result_t want;
    if (rst) rsp.ready <= 1'b0;
    else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response transfer at %0t", $realtime);
        end else begin
          want = pending_results.pop_front();
          if (rsp.payload_address !== want.payload_address || rsp.block_bytes !== want.block_bytes
              || rsp.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: exp addr %h bytes %0d st %0d, got addr %h bytes %0d st %0d",
                       $realtime, want.payload_address, want.block_bytes, want.status,
                       rsp.payload_address, rsp.block_bytes, rsp.status);
          end
        end
      end
      rsp.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // run limit
  initial begin
    #200_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned aligns [6] = '{0, 1, 3, 64, 16, 24};
    int drain;
    req.valid = 1'b0; req.op = '0; req.address = '0; req.length = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_heap();
    test_alloc_free();
    test_add_region();
    for (int ph = 0; ph < 6; ph++) begin
      stall_pct = (ph == 2) ? 0 : $urandom_range(10, 60);
      gap_max = (ph == 4) ? 0 : $urandom_range(1, 8);
      set_alignment(aligns[ph]);
      test_random_traffic(175);
    end
    set_alignment(0);
    req.valid <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < 1_000_000) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

>>> next_fit_heap_allocator.f
+incdir+rtl
rtl/nfha_pkg.sv
rtl/nfha_if.sv
rtl/nfha_ram.sv
rtl/nfha_ctrl.sv
rtl/next_fit_heap_allocator.sv
bench/tb_next_fit_heap_allocator.sv
